### src/sfc_pkg.sv
package sfc_pkg;

  localparam int ITERS = 30;
  localparam int QW = 32;
  localparam int PW = 34;
  localparam int RW = 34;
  localparam int XW = 37;
  localparam int ZW = 33;
  localparam int CFG_W = 31;
  localparam int SQRT_STEPS = 31;

  localparam logic signed [QW-1:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [QW-1:0] GAIN_INV = 32'sd652032874;
  localparam logic signed [QW-1:0] INC_SIN = 32'sd955617432;
  localparam logic signed [QW-1:0] INC_COS = 32'sd489608852;
  localparam logic [31:0] PHI_EQ_T = 32'd3374645044;
  localparam logic [31:0] PHI_GAL_T = 32'd392893109;

  localparam logic [CFG_W-1:0] COS_OBL_RESET = 31'd985138864;
  localparam logic [CFG_W-1:0] SIN_OBL_RESET = 31'd427109969;

  localparam logic [1:0] KIND_EQ_GAL = 2'd0;
  localparam logic [1:0] KIND_GAL_EQ = 2'd1;
  localparam logic [1:0] KIND_EQ_ECL = 2'd2;
  localparam logic [1:0] KIND_ECL_EQ = 2'd3;

  localparam logic CFG_COS_OBL = 1'b0;
  localparam logic CFG_SIN_OBL = 1'b1;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [XW-1:0]   y;
    logic signed [XW-1:0]   x;
    logic signed [QW-1:0]   s;
  } lon_tag_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 33'sd536870912;
      1: a = 33'sd316933406;
      2: a = 33'sd167458907;
      3: a = 33'sd85004756;
      4: a = 33'sd42667331;
      5: a = 33'sd21354465;
      6: a = 33'sd10679838;
      7: a = 33'sd5340245;
      8: a = 33'sd2670163;
      9: a = 33'sd1335087;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41722;
      15: a = 33'sd20861;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2608;
      19: a = 33'sd1304;
      20: a = 33'sd652;
      21: a = 33'sd326;
      22: a = 33'sd163;
      23: a = 33'sd81;
      24: a = 33'sd41;
      25: a = 33'sd20;
      26: a = 33'sd10;
      27: a = 33'sd5;
      28: a = 33'sd3;
      29: a = 33'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return p[63:30];
  endfunction

  function automatic logic signed [QW-1:0] clamp_one(input logic signed [XW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > ONE_Q30) begin
      r = ONE_Q30;
    end else if (v < -ONE_Q30) begin
      r = -ONE_Q30;
    end else begin
      r = QW'(v);
    end
    return r;
  endfunction

endpackage

### src/sfc_if.sv
interface sfc_in_if #(parameter int ANGLE_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [ANGLE_BITS-1:0]        in_lon;
  logic signed [ANGLE_BITS-1:0] in_lat;

  modport source (output valid, kind, in_lon, in_lat, input ready);
  modport sink (input valid, kind, in_lon, in_lat, output ready);
  modport monitor (input valid, ready, kind, in_lon, in_lat);
endinterface

interface sfc_out_if #(parameter int ANGLE_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [ANGLE_BITS-1:0]        out_lon;
  logic signed [ANGLE_BITS-1:0] out_lat;

  modport source (output valid, out_lon, out_lat, input ready);
  modport sink (input valid, out_lon, out_lat, output ready);
  modport monitor (input valid, ready, out_lon, out_lat);
endinterface

### src/sfc_sincos.sv
module sfc_sincos #(
  parameter int TW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [31:0]                   angle,
  input  logic [TW-1:0]                 in_tag,
  output logic                          out_vld,
  output logic signed [sfc_pkg::QW-1:0] sin_val,
  output logic signed [sfc_pkg::QW-1:0] cos_val,
  output logic [TW-1:0]                 out_tag
);

  localparam int N = sfc_pkg::ITERS;

  logic                          vld  [0:N];
  logic signed [sfc_pkg::RW-1:0] x    [0:N];
  logic signed [sfc_pkg::RW-1:0] y    [0:N];
  logic signed [sfc_pkg::ZW-1:0] z    [0:N];
  logic [1:0]                    quad [0:N];
  logic [TW-1:0]                 tag  [0:N];

  logic signed [sfc_pkg::RW-1:0] c_m;
  logic signed [sfc_pkg::RW-1:0] s_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= sfc_pkg::RW'(sfc_pkg::GAIN_INV);
      y[0]    <= '0;
      z[0]    <= sfc_pkg::ZW'(angle[29:0]);
      quad[0] <= angle[31:30];
      tag[0]  <= in_tag;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][sfc_pkg::ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - sfc_pkg::atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + sfc_pkg::atan_turn(i);
        end
        quad[i+1] <= quad[i];
        tag[i+1]  <= tag[i];
      end
    end
  end

  // fold the quadrant back in
  always_comb begin
    case (quad[N])
      2'd0: begin
        c_m = x[N];
        s_m = y[N];
      end
      2'd1: begin
        c_m = -y[N];
        s_m = x[N];
      end
      2'd2: begin
        c_m = -x[N];
        s_m = -y[N];
      end
      default: begin
        c_m = y[N];
        s_m = -x[N];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= sfc_pkg::clamp_one(sfc_pkg::XW'(s_m));
      cos_val <= sfc_pkg::clamp_one(sfc_pkg::XW'(c_m));
      out_tag <= tag[N];
    end
  end

endmodule

### src/sfc_isqrt.sv
module sfc_isqrt #(
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [60:0]   sq,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [30:0]   root,
  output logic [TW-1:0] out_tag
);

  localparam int N = sfc_pkg::SQRT_STEPS;

  logic          vld [0:N];
  logic [60:0]   v   [0:N];
  logic [61:0]   r   [0:N];
  logic [TW-1:0] tag [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  // radicand is one minus the square
  always_ff @(posedge clk) begin
    if (en) begin
      v[0]   <= (61'd1 << 60) - sq;
      r[0]   <= '0;
      tag[0] <= in_tag;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int SH = 2 * (N - 1 - j);
    localparam logic [61:0] B = 62'd1 << SH;

    logic [61:0] trial;
    assign trial = r[j] + B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, v[j]} >= trial) begin
          v[j+1] <= v[j] - trial[60:0];
          r[j+1] <= (r[j] >> 1) + B;
        end else begin
          v[j+1] <= v[j];
          r[j+1] <= r[j] >> 1;
        end
        tag[j+1] <= tag[j];
      end
    end
  end

  assign out_vld = vld[N];
  assign root    = r[N][30:0];
  assign out_tag = tag[N];

endmodule

### src/sfc_atan2.sv
module sfc_atan2 #(
  parameter int TW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [sfc_pkg::XW-1:0] y_in,
  input  logic signed [sfc_pkg::XW-1:0] x_in,
  input  logic [TW-1:0]                 in_tag,
  output logic                          out_vld,
  output logic [31:0]                   angle,
  output logic [TW-1:0]                 out_tag
);

  localparam int N = sfc_pkg::ITERS;

  logic                          vld  [0:N];
  logic                          zero [0:N];
  logic signed [sfc_pkg::XW-1:0] x    [0:N];
  logic signed [sfc_pkg::XW-1:0] y    [0:N];
  logic signed [sfc_pkg::ZW-1:0] z    [0:N];
  logic [TW-1:0]                 tag  [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  // mirror the left half plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[sfc_pkg::XW-1]) begin
        x[0] <= -x_in;
        y[0] <= -y_in;
        z[0] <= sfc_pkg::ZW'(33'sh080000000);
      end else begin
        x[0] <= x_in;
        y[0] <= y_in;
        z[0] <= '0;
      end
      tag[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y[i][sfc_pkg::XW-1]) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + sfc_pkg::atan_turn(i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - sfc_pkg::atan_turn(i);
        end
        zero[i+1] <= zero[i];
        tag[i+1]  <= tag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle   <= zero[N] ? 32'd0 : z[N][31:0];
      out_tag <= tag[N];
    end
  end

endmodule

### src/sky_frame_conversion.sv
// Sky frame conversion between equatorial, galactic and ecliptic frames. One
// word (kind, in_lon, in_lat) in, one word (out_lon, out_lat) out; angles are
// binary fractions of a turn at ANGLE_BITS bits. The block takes one word per
// clock while in_word.ready is high; its depth is set by the two 30-step CORDIC
// pipelines (rotation, then vectoring) and the 31-step square root pipeline
// between them. A one-word skid stage behind the output register takes the
// overflow when the sink stalls, and in_word.ready drops while it is full,
// holding the whole pipeline. The obliquity registers are written through
// cfg_write/cfg_index/cfg_data and should change only when no word is
// in flight.
module sky_frame_conversion #(
  parameter int ANGLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  sfc_in_if.sink                        in_word,
  sfc_out_if.source                     out_word,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [sfc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int QW = sfc_pkg::QW;
  localparam int PW = sfc_pkg::PW;
  localparam int XW = sfc_pkg::XW;
  localparam int TAG_W = $bits(sfc_pkg::lon_tag_t);

  logic en;

  logic [sfc_pkg::CFG_W-1:0] cos_obl;
  logic [sfc_pkg::CFG_W-1:0] sin_obl;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_obl <= sfc_pkg::COS_OBL_RESET;
      sin_obl <= sfc_pkg::SIN_OBL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sfc_pkg::CFG_COS_OBL: cos_obl <= cfg_data;
        sfc_pkg::CFG_SIN_OBL: sin_obl <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  logic [ANGLE_BITS+31:0] lon_wide;
  logic [ANGLE_BITS+31:0] lat_wide;
  logic [31:0]            lon_turn;
  logic                   s0_vld;
  logic [1:0]             s0_kind;
  logic [31:0]            s0_lon;
  logic [31:0]            s0_lat;

  assign lon_wide = {in_word.in_lon, 32'd0};
  assign lat_wide = {in_word.in_lat, 32'd0};
  assign lon_turn = lon_wide[ANGLE_BITS+31:ANGLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_kind <= in_word.kind;
      s0_lat  <= lat_wide[ANGLE_BITS+31:ANGLE_BITS];
      if (in_word.kind[1]) begin
        s0_lon <= lon_turn;
      end else if (in_word.kind == sfc_pkg::KIND_EQ_GAL) begin
        s0_lon <= lon_turn - sfc_pkg::PHI_EQ_T;
      end else begin
        s0_lon <= lon_turn - sfc_pkg::PHI_GAL_T;
      end
    end
  end

  // sine and cosine of both angles
  logic                 sc_vld;
  logic [1:0]           sc_kind;
  logic signed [QW-1:0] sa;
  logic signed [QW-1:0] ca;
  logic signed [QW-1:0] sb;
  logic signed [QW-1:0] cb;

  sfc_sincos #(.TW(2)) u_sincos_lon (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s0_vld),
    .angle   (s0_lon),
    .in_tag  (s0_kind),
    .out_vld (sc_vld),
    .sin_val (sa),
    .cos_val (ca),
    .out_tag (sc_kind)
  );

  sfc_sincos #(.TW(1)) u_sincos_lat (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s0_vld),
    .angle   (s0_lat),
    .in_tag  (1'b0),
    .out_vld (),
    .sin_val (sb),
    .cos_val (cb),
    .out_tag ()
  );

  // first product rank
  logic signed [QW-1:0] ka;
  logic signed [QW-1:0] kb;

  always_comb begin
    if (sc_kind[1]) begin
      ka = QW'({1'b0, cos_obl});
      kb = QW'({1'b0, sin_obl});
    end else if (sc_kind == sfc_pkg::KIND_EQ_GAL) begin
      ka = sfc_pkg::INC_COS;
      kb = sfc_pkg::INC_SIN;
    end else begin
      ka = sfc_pkg::INC_COS;
      kb = -sfc_pkg::INC_SIN;
    end
  end

  logic                 m1_vld;
  logic [1:0]           m1_kind;
  logic signed [QW-1:0] m1_ka;
  logic signed [QW-1:0] m1_kb;
  logic signed [QW-1:0] a1;
  logic signed [PW-1:0] a2;
  logic signed [PW-1:0] a3;
  logic signed [PW-1:0] a4;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_kind <= sc_kind;
      m1_ka   <= ka;
      m1_kb   <= kb;
      a1      <= QW'(sfc_pkg::mulq(cb, sa));
      a2      <= sfc_pkg::mulq(cb, ca);
      a3      <= sfc_pkg::mulq(ka, sb);
      a4      <= sfc_pkg::mulq(kb, sb);
    end
  end

  // second product rank
  logic                 m2_vld;
  logic [1:0]           m2_kind;
  logic signed [PW-1:0] m2_a2;
  logic signed [PW-1:0] m2_a3;
  logic signed [PW-1:0] m2_a4;
  logic signed [PW-1:0] b1;
  logic signed [PW-1:0] b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (en) begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_kind <= m1_kind;
      m2_a2   <= a2;
      m2_a3   <= a3;
      m2_a4   <= a4;
      b1      <= sfc_pkg::mulq(m1_kb, a1);
      b2      <= sfc_pkg::mulq(m1_ka, a1);
    end
  end

  // combine into the atan2 pair and the arcsine argument
  logic signed [XW-1:0] lon_y;
  logic signed [XW-1:0] lat_arg;

  always_comb begin
    if (m2_kind == sfc_pkg::KIND_ECL_EQ) begin
      lon_y   = XW'(b2) - XW'(m2_a4);
      lat_arg = XW'(m2_a3) + XW'(b1);
    end else begin
      lon_y   = XW'(b2) + XW'(m2_a4);
      lat_arg = XW'(m2_a3) - XW'(b1);
    end
  end

  logic                 m3_vld;
  logic [1:0]           m3_kind;
  logic signed [XW-1:0] m3_y;
  logic signed [XW-1:0] m3_x;
  logic signed [QW-1:0] m3_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld <= 1'b0;
    end else if (en) begin
      m3_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_kind <= m2_kind;
      m3_y    <= lon_y;
      m3_x    <= XW'(m2_a2);
      m3_s    <= sfc_pkg::clamp_one(lat_arg);
    end
  end

  // square of the arcsine argument
  logic signed [63:0]    s_sq;
  logic                  m4_vld;
  logic [60:0]           m4_sq;
  sfc_pkg::lon_tag_t     m4_tag;

  assign s_sq = m3_s * m3_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_vld <= 1'b0;
    end else if (en) begin
      m4_vld <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4_sq       <= s_sq[60:0];
      m4_tag.kind <= m3_kind;
      m4_tag.y    <= m3_y;
      m4_tag.x    <= m3_x;
      m4_tag.s    <= m3_s;
    end
  end

  logic              sq_vld;
  logic [30:0]       sq_root;
  logic [TAG_W-1:0]  sq_tag_bits;
  sfc_pkg::lon_tag_t sq_tag;

  sfc_isqrt #(.TW(TAG_W)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (m4_vld),
    .sq      (m4_sq),
    .in_tag  (m4_tag),
    .out_vld (sq_vld),
    .root    (sq_root),
    .out_tag (sq_tag_bits)
  );

  assign sq_tag = sfc_pkg::lon_tag_t'(sq_tag_bits);

  // longitude and latitude angles
  logic        at_vld;
  logic [1:0]  at_kind;
  logic [31:0] lon_t;
  logic [31:0] lat_t;

  sfc_atan2 #(.TW(2)) u_atan2_lon (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (sq_vld),
    .y_in    (sq_tag.y),
    .x_in    (sq_tag.x),
    .in_tag  (sq_tag.kind),
    .out_vld (at_vld),
    .angle   (lon_t),
    .out_tag (at_kind)
  );

  sfc_atan2 #(.TW(1)) u_atan2_lat (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (sq_vld),
    .y_in    (XW'(sq_tag.s)),
    .x_in    (XW'(sq_root)),
    .in_tag  (1'b0),
    .out_vld (),
    .angle   (lat_t),
    .out_tag ()
  );

  // offset, clamp and rescale
  logic [31:0]            lon_fin;
  logic signed [QW-1:0]   lat_fin;
  logic [ANGLE_BITS+31:0] lon_ext;
  logic [ANGLE_BITS+31:0] lat_ext;

  always_comb begin
    if (at_kind[1]) begin
      lon_fin = lon_t;
    end else if (at_kind == sfc_pkg::KIND_EQ_GAL) begin
      lon_fin = lon_t + sfc_pkg::PHI_GAL_T;
    end else begin
      lon_fin = lon_t + sfc_pkg::PHI_EQ_T;
    end
    lat_fin = sfc_pkg::clamp_one(XW'($signed(lat_t)));
  end

  assign lon_ext = {lon_fin, ANGLE_BITS'(0)};
  assign lat_ext = {lat_fin, ANGLE_BITS'(0)};

  logic                  last_vld;
  logic [ANGLE_BITS-1:0] last_lon;
  logic [ANGLE_BITS-1:0] last_lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_vld <= 1'b0;
    end else if (en) begin
      last_vld <= at_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_lon <= lon_ext[ANGLE_BITS+31:32];
      last_lat <= lat_ext[ANGLE_BITS+31:32];
    end
  end

  // output register and skid word
  logic                  out_vld;
  logic [ANGLE_BITS-1:0] out_lon;
  logic [ANGLE_BITS-1:0] out_lat;
  logic                  skid_vld;
  logic [ANGLE_BITS-1:0] skid_lon;
  logic [ANGLE_BITS-1:0] skid_lat;

  assign en = !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!skid_vld) begin
      if (out_vld && !out_word.ready) begin
        skid_vld <= last_vld;
      end else begin
        out_vld <= last_vld;
      end
    end else if (out_word.ready) begin
      skid_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld) begin
      if (out_vld && !out_word.ready) begin
        skid_lon <= last_lon;
        skid_lat <= last_lat;
      end else begin
        out_lon <= last_lon;
        out_lat <= last_lat;
      end
    end else if (out_word.ready) begin
      out_lon <= skid_lon;
      out_lat <= skid_lat;
    end
  end

  assign in_word.ready    = en;
  assign out_word.valid   = out_vld;
  assign out_word.out_lon = out_lon;
  assign out_word.out_lat = out_lat;

endmodule

### src/sfc_check.sv
module sfc_check #(
  parameter int ANGLE_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  sfc_in_if.sink     in_word,
  sfc_out_if.source  out_word
);

  localparam logic signed [ANGLE_BITS-1:0] LAT_MAX =
    signed'(ANGLE_BITS'(1) << (ANGLE_BITS - 2));

  assert property (@(posedge clk) rst |=> !out_word.valid)
    else $error("output word valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    !in_word.ready |-> $past(out_word.valid && !out_word.ready))
    else $error("input held off without an output stall");

  assert property (@(posedge clk) disable iff (rst)
    out_word.valid && !out_word.ready |=>
      out_word.valid && $stable(out_word.out_lon) && $stable(out_word.out_lat))
    else $error("stalled output word changed");

  assert property (@(posedge clk) disable iff (rst)
    out_word.valid |-> (out_word.out_lat <= LAT_MAX) && (out_word.out_lat >= -LAT_MAX))
    else $error("output latitude beyond a quarter turn");

endmodule

bind sky_frame_conversion sfc_check #(.ANGLE_BITS(ANGLE_BITS)) u_check (
  .clk      (clk),
  .rst      (rst),
  .in_word  (in_word),
  .out_word (out_word)
);
